@@ src/htsl_pkg.sv @@
// shared types and constants for the housekeeping tick and status led unit
`timescale 1ns / 1ps
package htsl_pkg;

  localparam int ELAPSED_BITS_DEF = 16;

  localparam int HOUR_W   = 5;
  localparam int FLAGS_W  = 5;
  localparam int COLOR_W  = 8;
  localparam int BRIGHT_W = 8;
  localparam int HEALTH_W = 16;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int PH_TEN_W     = 4;
  localparam int PH_MINUTE_W  = 7;
  localparam int PH_TEN_MIN_W = 11;

  localparam logic [PH_TEN_W-1:0]     PH_TEN_LAST     = PH_TEN_W'(9);
  localparam logic [PH_MINUTE_W-1:0]  PH_MINUTE_LAST  = PH_MINUTE_W'(119);
  localparam logic [PH_MINUTE_W-1:0]  PH_MINUTE_HALF  = PH_MINUTE_W'(60);
  localparam logic [PH_TEN_MIN_W-1:0] PH_TEN_MIN_LAST = PH_TEN_MIN_W'(1199);

  localparam logic [HOUR_W-1:0]   NIGHT_START_RST = HOUR_W'(22);
  localparam logic [HOUR_W-1:0]   NIGHT_END_RST   = HOUR_W'(6);
  localparam logic [BRIGHT_W-1:0] NIGHT_BRIGHT_RST = BRIGHT_W'(32);
  localparam logic [BRIGHT_W-1:0] DAY_BRIGHT_RST   = BRIGHT_W'(255);
  localparam logic [HEALTH_W-1:0] HEALTHY_RST      = HEALTH_W'(600);

  localparam logic [COLOR_W-1:0] LVL_FULL  = COLOR_W'(255);
  localparam logic [COLOR_W-1:0] LVL_AMBER = COLOR_W'(128);
  localparam logic [COLOR_W-1:0] LVL_GREEN = COLOR_W'(200);
  localparam logic [COLOR_W-1:0] LVL_OFF   = COLOR_W'(0);

  // status flag bit positions
  localparam int FLAG_MOTOR_ALARM   = 0;
  localparam int FLAG_WIND_OVERRIDE = 1;
  localparam int FLAG_TEMP_FAULT    = 2;
  localparam int FLAG_WIND_FAULT    = 3;
  localparam int FLAG_CALIBRATING   = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_NIGHT_START  = 3'd0,
    CFG_NIGHT_END    = 3'd1,
    CFG_NIGHT_BRIGHT = 3'd2,
    CFG_DAY_BRIGHT   = 3'd3,
    CFG_HEALTHY      = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [HOUR_W-1:0]  hour_of_day;
    logic [FLAGS_W-1:0] status_flags;
  } tick_t;

  typedef struct packed {
    logic               heartbeat;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               uptime_strobe;
    logic               heap_report_strobe;
    logic               heap_check_strobe;
    logic               stack_sweep_strobe;
    logic               healthy_mark;
  } led_t;

endpackage

@@ src/htsl_if.sv @@
// valid/ready channel interfaces for ticks, led results and register writes
`timescale 1ns / 1ps
interface htsl_tick_if;
  logic           valid;
  logic           ready;
  htsl_pkg::tick_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface htsl_led_if;
  logic           valid;
  logic           ready;
  htsl_pkg::led_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface htsl_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [htsl_pkg::CFG_INDEX_W-1:0]    index;
  logic [htsl_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/housekeeping_tick_status_led_unit.sv @@
// housekeeping tick unit: heartbeat, status colour, periodic strobes, healthy mark
// an accepted tick is registered in the tick stage, then in the result register that drives out
// throughput: one tick per cycle while out is not stalled, set by the tick stage and the colour stage
// an empty tick stage lets a new tick in while a finished beat waits on out
// reset clears all counters, the heartbeat and the healthy mark, and loads
// register defaults (night 22..6, brightness 32/255, healthy at 600 ticks)
`timescale 1ns / 1ps
module housekeeping_tick_status_led_unit #(
  parameter int ELAPSED_BITS = htsl_pkg::ELAPSED_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  htsl_tick_if.sink  tick_in,
  htsl_led_if.source led_out,
  htsl_cfg_if.sink   cfg
);
  import htsl_pkg::*;

  localparam int CMP_W = (ELAPSED_BITS > HEALTH_W) ? ELAPSED_BITS : HEALTH_W;

  typedef struct packed {
    logic [HOUR_W-1:0]  hour;
    logic [FLAGS_W-1:0] flags;
    logic               heartbeat;
    logic               uptime;
    logic               heap_report;
    logic               heap_check;
    logic               stack_sweep;
    logic               mark;
  } stage_t;

  // configuration registers
  logic [HOUR_W-1:0]   night_start_hour;
  logic [HOUR_W-1:0]   night_end_hour;
  logic [BRIGHT_W-1:0] night_brightness;
  logic [BRIGHT_W-1:0] day_brightness;
  logic [HEALTH_W-1:0] healthy_ticks;

  // tick state
  logic [PH_TEN_W-1:0]     phase_ten;
  logic [PH_MINUTE_W-1:0]  phase_minute;
  logic [PH_TEN_MIN_W-1:0] phase_ten_minutes;
  logic                    past_first_tick;
  logic [ELAPSED_BITS-1:0] elapsed_ticks;
  logic                    healthy_done;
  logic                    heartbeat_level;

  logic   s1_valid;
  stage_t s1;
  logic   out_valid;
  led_t   out_data;

  logic   tick_acc;
  logic   advance;
  logic   mark_now;
  logic   elapsed_below;
  stage_t s1_next;

  logic                night;
  logic [BRIGHT_W-1:0] dim;
  logic [COLOR_W-1:0]  base_r, base_g, base_b;
  logic [15:0]         prod_r, prod_g, prod_b;
  led_t                out_next;

  assign advance       = !out_valid || led_out.ready;
  assign tick_in.ready = !s1_valid || advance;
  assign tick_acc      = tick_in.valid && tick_in.ready;
  assign cfg.ready     = 1'b1;
  assign led_out.valid = out_valid;
  assign led_out.data  = out_data;

  always_comb begin
    elapsed_below = CMP_W'(elapsed_ticks) < CMP_W'(healthy_ticks);
    mark_now      = !healthy_done && !elapsed_below;
    s1_next.hour        = tick_in.data.hour_of_day;
    s1_next.flags       = tick_in.data.status_flags;
    s1_next.heartbeat   = !heartbeat_level;
    s1_next.uptime      = (phase_ten == '0);
    s1_next.heap_report = (phase_minute == '0);
    s1_next.heap_check  = (phase_minute == PH_MINUTE_HALF);
    s1_next.stack_sweep = past_first_tick && (phase_ten_minutes == '0);
    s1_next.mark        = mark_now;
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      night_start_hour <= NIGHT_START_RST;
      night_end_hour   <= NIGHT_END_RST;
      night_brightness <= NIGHT_BRIGHT_RST;
      day_brightness   <= DAY_BRIGHT_RST;
      healthy_ticks    <= HEALTHY_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_NIGHT_START:  night_start_hour <= cfg.data[HOUR_W-1:0];
        CFG_NIGHT_END:    night_end_hour   <= cfg.data[HOUR_W-1:0];
        CFG_NIGHT_BRIGHT: night_brightness <= cfg.data[BRIGHT_W-1:0];
        CFG_DAY_BRIGHT:   day_brightness   <= cfg.data[BRIGHT_W-1:0];
        CFG_HEALTHY:      healthy_ticks    <= cfg.data[HEALTH_W-1:0];
        default: ;
      endcase
    end
  end

  // tick stage: counters advance on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ten         <= '0;
      phase_minute      <= '0;
      phase_ten_minutes <= '0;
      past_first_tick   <= 1'b0;
      elapsed_ticks     <= '0;
      healthy_done      <= 1'b0;
      heartbeat_level   <= 1'b0;
      s1_valid          <= 1'b0;
    end else begin
      if (tick_acc) begin
        phase_ten         <= (phase_ten >= PH_TEN_LAST) ? '0 : phase_ten + 1'b1;
        phase_minute      <= (phase_minute >= PH_MINUTE_LAST) ? '0 : phase_minute + 1'b1;
        phase_ten_minutes <= (phase_ten_minutes >= PH_TEN_MIN_LAST) ? '0
                             : phase_ten_minutes + 1'b1;
        past_first_tick   <= 1'b1;
        heartbeat_level   <= !heartbeat_level;
        if (mark_now) begin
          healthy_done <= 1'b1;
        end
        if (elapsed_below && (elapsed_ticks != '1)) begin
          elapsed_ticks <= elapsed_ticks + 1'b1;
        end
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      s1 <= s1_next;
    end
  end

  // colour stage
  always_comb begin
    if (night_start_hour <= night_end_hour) begin
      night = (s1.hour >= night_start_hour) && (s1.hour < night_end_hour);
    end else begin
      night = (s1.hour >= night_start_hour) || (s1.hour < night_end_hour);
    end
    dim = night ? night_brightness : day_brightness;

    priority if (s1.flags[FLAG_MOTOR_ALARM] || s1.flags[FLAG_WIND_OVERRIDE]) begin
      base_r = LVL_FULL;  base_g = LVL_OFF;   base_b = LVL_OFF;
    end else if (s1.flags[FLAG_TEMP_FAULT] || s1.flags[FLAG_WIND_FAULT]) begin
      base_r = LVL_FULL;  base_g = LVL_AMBER; base_b = LVL_OFF;
    end else if (s1.flags[FLAG_CALIBRATING]) begin
      base_r = LVL_OFF;   base_g = LVL_OFF;   base_b = LVL_FULL;
    end else begin
      base_r = LVL_OFF;   base_g = LVL_GREEN; base_b = LVL_OFF;
    end

    prod_r = 16'(base_r) * 16'(dim);
    prod_g = 16'(base_g) * 16'(dim);
    prod_b = 16'(base_b) * 16'(dim);

    out_next.heartbeat          = s1.heartbeat;
    out_next.red                = prod_r[15:8];
    out_next.green              = prod_g[15:8];
    out_next.blue               = prod_b[15:8];
    out_next.uptime_strobe      = s1.uptime;
    out_next.heap_report_strobe = s1.heap_report;
    out_next.heap_check_strobe  = s1.heap_check;
    out_next.stack_sweep_strobe = s1.stack_sweep;
    out_next.healthy_mark       = s1.mark;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_data <= out_next;
    end
  end

  a_heartbeat_toggles: assert property (@(posedge clk) disable iff (rst)
    tick_acc |=> heartbeat_level != $past(heartbeat_level))
    else $error("heartbeat did not toggle on an accepted tick");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    (phase_ten <= PH_TEN_LAST) && (phase_minute <= PH_MINUTE_LAST)
    && (phase_ten_minutes <= PH_TEN_MIN_LAST))
    else $error("phase counter out of range");

  a_healthy_sticky: assert property (@(posedge clk) disable iff (rst)
    healthy_done |=> healthy_done)
    else $error("healthy mark cleared without reset");

  a_elapsed_idle: assert property (@(posedge clk) disable iff (rst)
    !tick_acc |=> $stable(elapsed_ticks) && $stable(phase_ten))
    else $error("tick state moved without an accepted tick");

  a_mark_once: assert property (@(posedge clk) disable iff (rst)
    (tick_acc && mark_now) |=> healthy_done && !mark_now)
    else $error("healthy mark armed twice");

endmodule

@@ verif/housekeeping_tick_status_led_unit_tb.sv @@
// self-checking testbench for the housekeeping tick status led unit
`timescale 1ns / 1ps
module housekeeping_tick_status_led_unit_tb;
  import htsl_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 6;
  localparam logic [CFG_INDEX_W-1:0] CFG_NO_REG = 3'd5;

  logic clk = 1'b0;
  logic rst;

  htsl_tick_if tick_if ();
  htsl_led_if  led_if ();
  htsl_cfg_if  cfg_if ();

  housekeeping_tick_status_led_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .tick_in (tick_if),
    .led_out (led_if),
    .cfg     (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copies
  logic [HOUR_W-1:0]   cf_night_start;
  logic [HOUR_W-1:0]   cf_night_end;
  logic [BRIGHT_W-1:0] cf_night_bright;
  logic [BRIGHT_W-1:0] cf_day_bright;
  logic [HEALTH_W-1:0] cf_healthy;

  // tick state copies
  logic [PH_TEN_W-1:0]         ph_ten;
  logic [PH_MINUTE_W-1:0]      ph_min;
  logic [PH_TEN_MIN_W-1:0]     ph_ten_min;
  logic                        seen_tick;
  logic [ELAPSED_BITS_DEF-1:0] elapsed;
  logic                        mark_done;
  logic                        hb_level;

  led_t led_pending[$];
  int   mismatches = 0;
  int   silent_cycles = 0;
  bit   no_idling = 1'b0;
  bit   hold_off_req = 1'b0;

  function automatic led_t advance_tick(tick_t t);
    led_t r;
    logic [COLOR_W-1:0] br, bg, bb, dim;
    logic night;
    hb_level = ~hb_level;
    if (t.status_flags[FLAG_MOTOR_ALARM] || t.status_flags[FLAG_WIND_OVERRIDE]) begin
      {br, bg, bb} = {LVL_FULL, LVL_OFF, LVL_OFF};
    end else if (t.status_flags[FLAG_TEMP_FAULT] || t.status_flags[FLAG_WIND_FAULT]) begin
      {br, bg, bb} = {LVL_FULL, LVL_AMBER, LVL_OFF};
    end else if (t.status_flags[FLAG_CALIBRATING]) begin
      {br, bg, bb} = {LVL_OFF, LVL_OFF, LVL_FULL};
    end else begin
      {br, bg, bb} = {LVL_OFF, LVL_GREEN, LVL_OFF};
    end
    if (cf_night_start <= cf_night_end) begin
      night = (t.hour_of_day >= cf_night_start) && (t.hour_of_day < cf_night_end);
    end else begin
      night = (t.hour_of_day >= cf_night_start) || (t.hour_of_day < cf_night_end);
    end
    dim = night ? cf_night_bright : cf_day_bright;
    r.heartbeat = hb_level;
    r.red   = COLOR_W'((16'(br) * 16'(dim)) >> 8);
    r.green = COLOR_W'((16'(bg) * 16'(dim)) >> 8);
    r.blue  = COLOR_W'((16'(bb) * 16'(dim)) >> 8);
    r.uptime_strobe      = (ph_ten == '0);
    r.heap_report_strobe = (ph_min == '0);
    r.heap_check_strobe  = (ph_min == PH_MINUTE_HALF);
    r.stack_sweep_strobe = seen_tick && (ph_ten_min == '0);
    r.healthy_mark = 1'b0;
    if (!mark_done && 32'(elapsed) >= 32'(cf_healthy)) begin
      mark_done = 1'b1;
      r.healthy_mark = 1'b1;
    end
    ph_ten     = (ph_ten >= PH_TEN_LAST) ? '0 : ph_ten + 1'b1;
    ph_min     = (ph_min >= PH_MINUTE_LAST) ? '0 : ph_min + 1'b1;
    ph_ten_min = (ph_ten_min >= PH_TEN_MIN_LAST) ? '0 : ph_ten_min + 1'b1;
    seen_tick  = 1'b1;
    if (32'(elapsed) < 32'(cf_healthy) && elapsed != '1) elapsed = elapsed + 1'b1;
    return r;
  endfunction

  function automatic void check_field(string name, logic [COLOR_W-1:0] want,
                                      logic [COLOR_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    if ($urandom_range(0, 9) == 0) t.hour_of_day = HOUR_W'($urandom_range(24, 31));
    else t.hour_of_day = HOUR_W'($urandom_range(0, 23));
    if ($urandom_range(0, 1) == 0) t.status_flags = FLAGS_W'(1 << $urandom_range(0, FLAGS_W - 1));
    else t.status_flags = FLAGS_W'($urandom_range(0, 31));
    return t;
  endfunction

  // random upper bits above the register width, on about half the calls
  function automatic logic [CFG_DATA_W-1:0] with_noise(int unsigned v, int w);
    logic [CFG_DATA_W-1:0] m;
    m = CFG_DATA_W'((1 << w) - 1);
    if ($urandom_range(0, 1) == 0) return (CFG_DATA_W'($urandom) & ~m) | CFG_DATA_W'(v);
    return CFG_DATA_W'(v);
  endfunction

  function automatic int unsigned random_bright();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic send_tick(tick_t t);
    if (!no_idling && $urandom_range(0, 5) == 0) begin
      tick_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    tick_if.valid <= 1'b1;
    tick_if.data  <= t;
    do @(posedge clk); while (!tick_if.ready);
    led_pending.push_back(advance_tick(t));
  endtask

  task automatic stop_ticks();
    tick_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (led_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_NIGHT_START:  cf_night_start  = HOUR_W'(val);
      CFG_NIGHT_END:    cf_night_end    = HOUR_W'(val);
      CFG_NIGHT_BRIGHT: cf_night_bright = BRIGHT_W'(val);
      CFG_DAY_BRIGHT:   cf_day_bright   = BRIGHT_W'(val);
      CFG_HEALTHY:      cf_healthy      = HEALTH_W'(val);
      default: ;
    endcase
  endtask

  task automatic cfg_release();
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_window(int unsigned s, int unsigned e, int unsigned nb, int unsigned db);
    stop_ticks();
    wait_drained();
    cfg_write(CFG_NIGHT_START, CFG_DATA_W'(s));
    cfg_write(CFG_NIGHT_END, CFG_DATA_W'(e));
    cfg_write(CFG_NIGHT_BRIGHT, CFG_DATA_W'(nb));
    cfg_write(CFG_DAY_BRIGHT, CFG_DATA_W'(db));
    cfg_release();
  endtask

  task automatic program_random_settings();
    int unsigned s, e;
    stop_ticks();
    wait_drained();
    s = $urandom_range(0, 23);
    e = ($urandom_range(0, 5) == 0) ? s : $urandom_range(0, 23);
    cfg_write(CFG_NIGHT_START, with_noise(s, HOUR_W));
    cfg_write(CFG_NIGHT_END, with_noise(e, HOUR_W));
    cfg_write(CFG_NIGHT_BRIGHT, with_noise(random_bright(), BRIGHT_W));
    cfg_write(CFG_DAY_BRIGHT, with_noise(random_bright(), BRIGHT_W));
    cfg_write(CFG_HEALTHY, CFG_DATA_W'($urandom_range(0, 65535)));
    cfg_write(CFG_NO_REG, CFG_DATA_W'($urandom));
    cfg_release();
  endtask

  // healthy mark on the very first tick
  task automatic test_zero_threshold();
    cfg_write(CFG_HEALTHY, '0);
    cfg_release();
    send_tick(tick_t'{HOUR_W'(0), FLAGS_W'(0)});
  endtask

  task automatic test_colour_priority();
    logic [FLAGS_W-1:0] flag_set[10] = '{5'h00, 5'h01, 5'h02, 5'h04, 5'h08,
                                         5'h10, 5'h03, 5'h0c, 5'h18, 5'h1f};
    foreach (flag_set[i]) send_tick(tick_t'{HOUR_W'(12), flag_set[i]});
    send_tick(tick_t'{HOUR_W'(23), FLAGS_W'(5'h10)});
  endtask

  task automatic test_night_window();
    // empty window, hours above 23
    set_window(6, 6, 255, 128);
    cfg_write(CFG_HEALTHY, CFG_DATA_W'(65535));
    cfg_release();
    send_tick(tick_t'{HOUR_W'(6), FLAGS_W'(0)});
    send_tick(tick_t'{HOUR_W'(0), FLAGS_W'(5'h04)});
    send_tick(tick_t'{HOUR_W'(31), FLAGS_W'(5'h01)});
    set_window(0, 23, 255, 0);
    send_tick(tick_t'{HOUR_W'(0), FLAGS_W'(5'h1f)});
    send_tick(tick_t'{HOUR_W'(22), FLAGS_W'(5'h10)});
    send_tick(tick_t'{HOUR_W'(23), FLAGS_W'(5'h08)});
    send_tick(tick_t'{HOUR_W'(31), FLAGS_W'(0)});
    // window wrapping midnight
    set_window(23, 0, 0, 255);
    send_tick(tick_t'{HOUR_W'(23), FLAGS_W'(5'h02)});
    send_tick(tick_t'{HOUR_W'(31), FLAGS_W'(0)});
    send_tick(tick_t'{HOUR_W'(0), FLAGS_W'(5'h10)});
    send_tick(tick_t'{HOUR_W'(22), FLAGS_W'(5'h0c)});
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 5; p++) begin
      program_random_settings();
      repeat (145) send_tick(random_tick());
    end
  endtask

  task automatic test_backpressure();
    program_random_settings();
    hold_off_req = 1'b1;
    repeat (100) send_tick(random_tick());
  endtask

  task automatic test_quiet_tail();
    program_random_settings();
    no_idling = 1'b1;
    repeat (200) send_tick(random_tick());
  endtask

  initial begin
    rst <= 1'b1;
    tick_if.valid <= 1'b0;
    tick_if.data  <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= '0;
    cfg_if.data   <= '0;
    cf_night_start  = NIGHT_START_RST;
    cf_night_end    = NIGHT_END_RST;
    cf_night_bright = NIGHT_BRIGHT_RST;
    cf_day_bright   = DAY_BRIGHT_RST;
    cf_healthy      = HEALTHY_RST;
    ph_ten     = '0;
    ph_min     = '0;
    ph_ten_min = '0;
    seen_tick  = 1'b0;
    elapsed    = '0;
    mark_done  = 1'b0;
    hb_level   = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_zero_threshold();
    test_colour_priority();
    test_night_window();
    test_random_settings();
    test_backpressure();
    test_quiet_tail();
    stop_ticks();
    wait_drained();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // result sink: random stalls, one long hold-off on request
  initial begin
    led_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        led_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        led_if.ready <= 1'b1;
      end else if (!no_idling && $urandom_range(0, 7) == 0) begin
        led_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        led_if.ready <= 1'b1;
      end else begin
        led_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : led_check
    led_t want;
    if (!rst && led_if.valid && led_if.ready) begin
      if (led_pending.size() == 0) begin
        $error("led beat with no tick pending");
        mismatches++;
      end else begin
        want = led_pending.pop_front();
        check_field("heartbeat", want.heartbeat, led_if.data.heartbeat);
        check_field("red", want.red, led_if.data.red);
        check_field("green", want.green, led_if.data.green);
        check_field("blue", want.blue, led_if.data.blue);
        check_field("uptime_strobe", want.uptime_strobe, led_if.data.uptime_strobe);
        check_field("heap_report_strobe", want.heap_report_strobe,
                    led_if.data.heap_report_strobe);
        check_field("heap_check_strobe", want.heap_check_strobe,
                    led_if.data.heap_check_strobe);
        check_field("stack_sweep_strobe", want.stack_sweep_strobe,
                    led_if.data.stack_sweep_strobe);
        check_field("healthy_mark", want.healthy_mark, led_if.data.healthy_mark);
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (tick_if.valid && tick_if.ready) || (led_if.valid && led_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      silent_cycles <= 0;
    end else begin
      silent_cycles <= silent_cycles + 1;
    end
    if (silent_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
